/* hdl/lcdfmt_pkg.sv */
// ----------------------------------------------------------------------------
// lcdfmt_pkg
// shared types and constants of the lcd window / pixel byte formatter
// ----------------------------------------------------------------------------
`default_nettype none

package lcdfmt_pkg;

    // pixel packing formats
    typedef enum logic [1:0] {
        FMT_12 = 2'd0,
        FMT_16 = 2'd1,
        FMT_18 = 2'd2,
        FMT_24 = 2'd3
    } t_pix_fmt;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 8;
    localparam int unsigned CFG_DATA_W  = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_FORMAT     = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_SET_CODE  = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PAGE_SET_CODE    = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MEMORY_WRITE_CODE = 8'd3;

    // register reset values
    localparam t_pix_fmt   RST_PIXEL_FORMAT      = FMT_24;
    localparam logic [7:0] RST_COLUMN_SET_CODE   = 8'd42;
    localparam logic [7:0] RST_PAGE_SET_CODE     = 8'd43;
    localparam logic [7:0] RST_MEMORY_WRITE_CODE = 8'd44;

    // input beat
    typedef struct packed {
        logic        op;
        logic [15:0] x_start;
        logic [15:0] y_start;
        logic [15:0] x_end;
        logic [15:0] y_end;
        logic [23:0] pixel_color;
        logic        final_pixel;
    } t_in_item;

    localparam logic OP_WINDOW = 1'b0;
    localparam logic OP_PIXEL  = 1'b1;

    // result beat
    typedef struct packed {
        logic [7:0] bus_byte;
        logic       is_command;
        logic       run_end;
    } t_out_item;

    // job kinds passed from front to back
    typedef enum logic [1:0] {
        JOB_WINDOW = 2'd0,
        JOB_PIX2   = 2'd1,
        JOB_PIX3   = 2'd2
    } t_job_kind;

    // window: {x_start, x_end, y_start, y_end}; pixel: bytes in [23:0], first in [23:16]
    typedef struct packed {
        t_job_kind   kind;
        logic [63:0] data;
    } t_job;

    typedef struct packed {
        logic [7:0] column_set;
        logic [7:0] page_set;
        logic [7:0] ram_write;
    } t_cmd_codes;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    localparam int unsigned STEP_W = 4;
    localparam logic [STEP_W-1:0] LAST_STEP_WINDOW = 4'd10;
    localparam logic [STEP_W-1:0] LAST_STEP_PIX2   = 4'd1;
    localparam logic [STEP_W-1:0] LAST_STEP_PIX3   = 4'd2;

endpackage

`default_nettype wire

/* hdl/lcdfmt_front.sv */
// ----------------------------------------------------------------------------
// lcdfmt_front
// classifies accepted beats, packs pixels and keeps the held 12-bit pixel
// ----------------------------------------------------------------------------
`default_nettype none

module lcdfmt_front
    import lcdfmt_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_accept,
    input  wire t_in_item i_item,
    input  wire t_pix_fmt i_pixel_format,
    output logic          o_job_valid,
    output t_job          o_job
);

    logic [23:0] r_held_color;
    logic        r_held_valid;
    logic [23:0] n_held_color;
    logic        n_held_valid;

    logic [23:0] p0;
    logic [23:0] p1;
    logic [7:0]  red;
    logic [7:0]  grn;
    logic [7:0]  blu;

    assign red = i_item.pixel_color[23:16];
    assign grn = i_item.pixel_color[15:8];
    assign blu = i_item.pixel_color[7:0];

    // 12-bit pair: held pixel first, else the new one paired with black
    assign p0 = r_held_valid ? r_held_color : i_item.pixel_color;
    assign p1 = r_held_valid ? i_item.pixel_color : 24'd0;

    always_comb begin
        o_job_valid  = 1'b1;
        o_job.kind   = JOB_PIX3;
        o_job.data   = '0;
        n_held_color = 24'd0;
        n_held_valid = 1'b0;
        if (i_item.op == OP_WINDOW) begin
            o_job.kind = JOB_WINDOW;
            o_job.data = {i_item.x_start, i_item.x_end, i_item.y_start, i_item.y_end};
        end else begin
            unique case (i_pixel_format)
                FMT_12: begin
                    if (!r_held_valid && !i_item.final_pixel) begin
                        o_job_valid  = 1'b0;
                        n_held_color = i_item.pixel_color;
                        n_held_valid = 1'b1;
                    end
                    o_job.data[23:0] = {p0[23:20], p0[15:12], p0[7:4], p1[23:20],
                                        p1[15:12], p1[7:4]};
                end
                FMT_16: begin
                    o_job.kind       = JOB_PIX2;
                    o_job.data[23:0] = {red[7:3], grn[7:5], grn[4:2], blu[7:3], 8'd0};
                end
                FMT_18: begin
                    o_job.data[23:0] = {red[7:2], 2'b00, grn[7:2], 2'b00, blu[7:2], 2'b00};
                end
                FMT_24: begin
                    o_job.data[23:0] = i_item.pixel_color;
                end
                default: begin
                    o_job.data[23:0] = i_item.pixel_color;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_color <= 24'd0;
            r_held_valid <= 1'b0;
        end else if (i_accept) begin
            r_held_color <= n_held_color;
            r_held_valid <= n_held_valid;
        end
    end

endmodule

`default_nettype wire

/* hdl/lcdfmt_queue.sv */
// ----------------------------------------------------------------------------
// lcdfmt_queue
// short job queue between the front and the byte sequencer
// ----------------------------------------------------------------------------
`default_nettype none

module lcdfmt_queue
    import lcdfmt_pkg::*;
#(
    parameter int unsigned DEPTH = 2
)(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_wr_en,
    input  wire t_job  i_wr_job,
    input  wire logic  i_rd_en,
    output t_job       o_head,
    output t_q_status  o_status
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             wr_go;
    logic             rd_go;

    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign wr_go = i_wr_en && !o_status.full;
    assign rd_go = i_rd_en && !o_status.empty;
    assign o_head = r_mem[r_rd_ptr];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (wr_go) begin
            r_mem[r_wr_ptr] <= i_wr_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_go) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (rd_go) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (wr_go && !rd_go) begin
                r_count <= r_count + CNT_W'(1);
            end else if (rd_go && !wr_go) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

/* hdl/lcdfmt_back.sv */
// ----------------------------------------------------------------------------
// lcdfmt_back
// walks the head job byte by byte into the output register
// ----------------------------------------------------------------------------
`default_nettype none

module lcdfmt_back
    import lcdfmt_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_job       i_head,
    input  wire logic       i_head_valid,
    input  wire t_cmd_codes i_codes,
    input  wire logic       i_pop,
    output logic            o_rd_en,
    output t_out_item       o_item,
    output logic            o_empty
);

    logic [STEP_W-1:0] r_step;
    logic              r_out_valid;
    t_out_item         r_out;
    logic [STEP_W-1:0] last_step;
    logic              advance;
    logic              load;
    logic              is_last;
    t_out_item         n_out;

    assign advance = !r_out_valid || i_pop;
    assign load    = advance && i_head_valid;

    always_comb begin
        unique case (i_head.kind)
            JOB_WINDOW: last_step = LAST_STEP_WINDOW;
            JOB_PIX2:   last_step = LAST_STEP_PIX2;
            JOB_PIX3:   last_step = LAST_STEP_PIX3;
            default:    last_step = LAST_STEP_PIX3;
        endcase
    end

    assign is_last = (r_step == last_step);
    assign o_rd_en = load && is_last;

    always_comb begin
        n_out.is_command = 1'b0;
        n_out.run_end    = is_last;
        n_out.bus_byte   = 8'd0;
        if (i_head.kind == JOB_WINDOW) begin
            unique case (r_step)
                4'd0: begin
                    n_out.bus_byte   = i_codes.column_set;
                    n_out.is_command = 1'b1;
                end
                4'd1:  n_out.bus_byte = i_head.data[63:56];
                4'd2:  n_out.bus_byte = i_head.data[55:48];
                4'd3:  n_out.bus_byte = i_head.data[47:40];
                4'd4:  n_out.bus_byte = i_head.data[39:32];
                4'd5: begin
                    n_out.bus_byte   = i_codes.page_set;
                    n_out.is_command = 1'b1;
                end
                4'd6:  n_out.bus_byte = i_head.data[31:24];
                4'd7:  n_out.bus_byte = i_head.data[23:16];
                4'd8:  n_out.bus_byte = i_head.data[15:8];
                4'd9:  n_out.bus_byte = i_head.data[7:0];
                4'd10: begin
                    n_out.bus_byte   = i_codes.ram_write;
                    n_out.is_command = 1'b1;
                end
                default: n_out.bus_byte = 8'd0;
            endcase
        end else begin
            unique case (r_step)
                4'd0:    n_out.bus_byte = i_head.data[23:16];
                4'd1:    n_out.bus_byte = i_head.data[15:8];
                4'd2:    n_out.bus_byte = i_head.data[7:0];
                default: n_out.bus_byte = 8'd0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= i_head_valid;
            if (load) begin
                r_step <= is_last ? '0 : r_step + STEP_W'(1);
            end
        end
    end

    assign o_item  = r_out;
    assign o_empty = !r_out_valid;

endmodule

`default_nettype wire

/* hdl/lcd_window_pixel_byte_formatter_unit.sv */
// ----------------------------------------------------------------------------
// lcd_window_pixel_byte_formatter_unit
// turns window and pixel requests into tagged bytes for an 8-bit lcd bus
// ----------------------------------------------------------------------------
// usage
//   input side is a queue: drive i_in_item and push, a beat goes in when
//   push is high and full is low. window beats give 11 bytes (column set,
//   x start/end, page set, y start/end, memory write); pixel beats give 2 or 3
//   bytes by pixel format, or none for the first pixel of a 12-bit pair
//   output side is a queue too: o_out_item is valid while empty is low and
//   leaves on pop. run_end marks the last byte of each input beat
//   config: i_cfg_valid/o_cfg_ready with register index and data; write only
//   while the block is drained. indexes past the list are dropped
// timing
//   a taken beat is registered into the job queue, the sequencer then loads its first
//   byte into the output register, then one byte a cycle while pop is held; the output
//   register is the limit. the job queue (QUEUE_DEPTH
//   entries) keeps taking beats while the sequencer works, full rises once it fills
// reset: synchronous, queues emptied, held pixel dropped, registers restored,
//   full held high while reset is low. a stalled pop simply freezes the output
// ----------------------------------------------------------------------------
`default_nettype none

module lcd_window_pixel_byte_formatter_unit
    import lcdfmt_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
)(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // input queue side
    input  wire logic                   push,
    output logic                        full,
    input  wire t_in_item               i_in_item,
    // result queue side
    output logic                        empty,
    input  wire logic                   pop,
    output t_out_item                   o_out_item,
    // config write channel
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);

    // config registers
    t_pix_fmt   r_pixel_format;
    t_cmd_codes r_codes;

    logic      in_accept;
    logic      cfg_write;
    logic      job_valid;
    t_job      job;
    t_job      head;
    t_q_status q_status;
    logic      q_rd_en;

    assign o_cfg_ready = i_rst_n;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_format     <= RST_PIXEL_FORMAT;
            r_codes.column_set <= RST_COLUMN_SET_CODE;
            r_codes.page_set   <= RST_PAGE_SET_CODE;
            r_codes.ram_write  <= RST_MEMORY_WRITE_CODE;
        end else if (cfg_write) begin
            unique case (i_cfg_index)
                REG_PIXEL_FORMAT:      r_pixel_format     <= t_pix_fmt'(i_cfg_data[1:0]);
                REG_COLUMN_SET_CODE:   r_codes.column_set <= i_cfg_data;
                REG_PAGE_SET_CODE:     r_codes.page_set   <= i_cfg_data;
                REG_MEMORY_WRITE_CODE: r_codes.ram_write  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // input handshake: blocked while in reset and while the job queue is full
    assign full      = !i_rst_n || q_status.full;
    assign in_accept = push && !full;

    // front: classify and pack, hold first 12-bit pixel
    lcdfmt_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (in_accept),
        .i_item         (i_in_item),
        .i_pixel_format (r_pixel_format),
        .o_job_valid    (job_valid),
        .o_job          (job)
    );

    // decoupling queue, only beats that make bytes enter it
    lcdfmt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr_en  (in_accept && job_valid),
        .i_wr_job (job),
        .i_rd_en  (q_rd_en),
        .o_head   (head),
        .o_status (q_status)
    );

    // back: byte sequencer with output register, job retires on its last byte
    lcdfmt_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_head_valid (!q_status.empty),
        .i_codes      (r_codes),
        .i_pop        (pop),
        .o_rd_en      (q_rd_en),
        .o_item       (o_out_item),
        .o_empty      (empty)
    );

    // a taken window beat leaves a byte on the output once the job queue and the output register are passed
    a_window_reaches_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in_item.op == OP_WINDOW) |-> ##2 !empty)
        else $error("window beat did not reach the output");

    // bytes of one input beat go out without gaps
    a_run_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && !o_out_item.run_end) |=> !empty)
        else $error("gap inside one beat's byte run");

    // the only command that closes a run is memory write
    a_cmd_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_item.is_command && o_out_item.run_end)
        |-> (o_out_item.bus_byte == r_codes.ram_write))
        else $error("run closed by a command other than memory write");

    // the job queue never overflows
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_status.full && !q_rd_en) |=> !(q_status.empty))
        else $error("job queue lost entries while full");

endmodule

`default_nettype wire

/* tb/lcd_byte_stream_checker.sv */
// ----------------------------------------------------------------------------
// lcd_byte_stream_checker
// watches the request, byte and register channels of the lcd formatter,
// predicts the tagged bus bytes of every accepted request and compares them
// in order with the bytes that leave the block
// ----------------------------------------------------------------------------
module lcd_byte_stream_checker
    import lcdfmt_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_push,
    input  wire logic                   i_full,
    input  wire t_in_item               i_in_item,
    input  wire logic                   i_empty,
    input  wire logic                   i_pop,
    input  wire t_out_item              i_out_item,
    input  wire logic                   i_cfg_valid,
    input  wire logic                   i_cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    output int                          o_fail_count,
    output int                          o_bytes_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // shadow registers and pixel pairing state
    t_pix_fmt    fmt_shadow;
    t_cmd_codes  code_shadow;
    logic [23:0] held_color;
    logic        held_valid;

    t_out_item   expected_bytes[$];

    function automatic void add_byte(input logic [7:0] value, input logic cmd);
        t_out_item ob;
        ob.bus_byte   = value;
        ob.is_command = cmd;
        ob.run_end    = 1'b0;
        expected_bytes.push_back(ob);
    endfunction

    function automatic void write_shadow(input logic [CFG_INDEX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_PIXEL_FORMAT:      fmt_shadow = t_pix_fmt'(val[1:0]);
            REG_COLUMN_SET_CODE:   code_shadow.column_set = val;
            REG_PAGE_SET_CODE:     code_shadow.page_set = val;
            REG_MEMORY_WRITE_CODE: code_shadow.ram_write = val;
            default: ;
        endcase
    endfunction

    function automatic void format_beat(input t_in_item beat);
        int unsigned queued;
        logic [23:0] p0;
        logic [23:0] p1;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        queued = expected_bytes.size();
        r = beat.pixel_color[23:16];
        g = beat.pixel_color[15:8];
        b = beat.pixel_color[7:0];
        if (beat.op == OP_WINDOW) begin
            held_valid = 1'b0;
            held_color = '0;
            add_byte(code_shadow.column_set, 1'b1);
            add_byte(beat.x_start[15:8], 1'b0);
            add_byte(beat.x_start[7:0], 1'b0);
            add_byte(beat.x_end[15:8], 1'b0);
            add_byte(beat.x_end[7:0], 1'b0);
            add_byte(code_shadow.page_set, 1'b1);
            add_byte(beat.y_start[15:8], 1'b0);
            add_byte(beat.y_start[7:0], 1'b0);
            add_byte(beat.y_end[15:8], 1'b0);
            add_byte(beat.y_end[7:0], 1'b0);
            add_byte(code_shadow.ram_write, 1'b1);
        end else if (fmt_shadow == FMT_12) begin
            if (held_valid) begin
                p0 = held_color;
                p1 = beat.pixel_color;
            end else if (beat.final_pixel) begin
                p0 = beat.pixel_color;
                p1 = '0;
            end else begin
                held_color = beat.pixel_color;
                held_valid = 1'b1;
                return;
            end
            held_valid = 1'b0;
            held_color = '0;
            add_byte({p0[23:20], p0[15:12]}, 1'b0);
            add_byte({p0[7:4], p1[23:20]}, 1'b0);
            add_byte({p1[15:12], p1[7:4]}, 1'b0);
        end else begin
            held_valid = 1'b0;
            held_color = '0;
            case (fmt_shadow)
                FMT_16: begin
                    add_byte({r[7:3], g[7:5]}, 1'b0);
                    add_byte({g[4:2], b[7:3]}, 1'b0);
                end
                FMT_18: begin
                    add_byte({r[7:2], 2'b00}, 1'b0);
                    add_byte({g[7:2], 2'b00}, 1'b0);
                    add_byte({b[7:2], 2'b00}, 1'b0);
                end
                default: begin
                    add_byte(r, 1'b0);
                    add_byte(g, 1'b0);
                    add_byte(b, 1'b0);
                end
            endcase
        end
        if (expected_bytes.size() > queued)
            expected_bytes[expected_bytes.size()-1].run_end = 1'b1;
    endfunction

    function automatic void check_byte(input t_out_item got);
        t_out_item want;
        if (expected_bytes.size() == 0) begin
            $display("%0t ns: unexpected byte, expected none actual %02h cmd %0b end %0b",
                     $time, got.bus_byte, got.is_command, got.run_end);
            o_fail_count++;
            return;
        end
        want = expected_bytes.pop_front();
        if (got.bus_byte !== want.bus_byte) begin
            $display("%0t ns: bus_byte expected %02h actual %02h",
                     $time, want.bus_byte, got.bus_byte);
            o_fail_count++;
        end
        if (got.is_command !== want.is_command) begin
            $display("%0t ns: is_command expected %0b actual %0b",
                     $time, want.is_command, got.is_command);
            o_fail_count++;
        end
        if (got.run_end !== want.run_end) begin
            $display("%0t ns: run_end expected %0b actual %0b",
                     $time, want.run_end, got.run_end);
            o_fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fmt_shadow             = RST_PIXEL_FORMAT;
            code_shadow.column_set = RST_COLUMN_SET_CODE;
            code_shadow.page_set   = RST_PAGE_SET_CODE;
            code_shadow.ram_write  = RST_MEMORY_WRITE_CODE;
            held_color             = '0;
            held_valid             = 1'b0;
            expected_bytes.delete();
        end else begin
            if (!i_empty && i_pop)
                check_byte(i_out_item);
            if (i_cfg_valid && i_cfg_ready)
                write_shadow(i_cfg_index, i_cfg_data);
            if (i_push && !i_full)
                format_beat(i_in_item);
        end
        o_bytes_pending = expected_bytes.size();
    end

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// drives window and pixel requests and register writes into the lcd
// formatter under random idle and pop stalls; the stream checker beside the
// block predicts every bus byte and counts mismatches for the verdict
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lcdfmt_pkg::*;

    // cycles to let a request settle when it may give no byte at all
    localparam int DRAIN_CYCLES = 8;
    // cycles with no accepted beat on any channel before giving up
    localparam int STALL_LIMIT  = 2000;
    localparam int PHASES       = 8;
    localparam int PHASE_BEATS  = 60;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   push        = 1'b0;
    logic                   full;
    t_in_item               i_in_item   = '0;
    logic                   empty;
    logic                   pop         = 1'b0;
    t_out_item              o_out_item;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;

    int fail_count;
    int bytes_pending;
    int stall_cycles = 0;
    // random idling on both sides, off for phases 2 and 5 and the closing phase
    bit idle_en = 1'b1;

    always begin
        #5ns i_clk = 1'b1;
        #5ns i_clk = 1'b0;
    end

    lcd_window_pixel_byte_formatter_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in_item   (i_in_item),
        .empty       (empty),
        .pop         (pop),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    lcd_byte_stream_checker u_stream_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .i_full          (full),
        .i_in_item       (i_in_item),
        .i_empty         (empty),
        .i_pop           (pop),
        .i_out_item      (o_out_item),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_bytes_pending (bytes_pending)
    );

    // window coordinate, biased toward the two ends of the range
    function automatic logic [15:0] pick_coord();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // mostly pixels; fields the op does not use are random noise
    function automatic t_in_item random_beat();
        t_in_item beat;
        beat.op          = ($urandom_range(0, 9) == 0) ? OP_WINDOW : OP_PIXEL;
        beat.x_start     = pick_coord();
        beat.y_start     = pick_coord();
        beat.x_end       = pick_coord();
        beat.y_end       = pick_coord();
        beat.pixel_color = 24'($urandom);
        beat.final_pixel = ($urandom_range(0, 5) == 0);
        return beat;
    endfunction

    function automatic t_in_item make_window(input logic [15:0] xs, input logic [15:0] xe,
                                             input logic [15:0] ys, input logic [15:0] ye);
        t_in_item beat;
        beat         = random_beat();
        beat.op      = OP_WINDOW;
        beat.x_start = xs;
        beat.x_end   = xe;
        beat.y_start = ys;
        beat.y_end   = ye;
        return beat;
    endfunction

    function automatic t_in_item make_pixel(input logic [23:0] color, input logic fin);
        t_in_item beat;
        beat             = random_beat();
        beat.op          = OP_PIXEL;
        beat.pixel_color = color;
        beat.final_pixel = fin;
        return beat;
    endfunction

    // one request beat, with an optional idle burst in front of it;
    // push is left high so back-to-back beats keep it asserted
    task automatic send_beat(input t_in_item beat);
        int gap;
        gap = (idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            push <= 1'b0;
        end
        @(negedge i_clk);
        push      <= 1'b1;
        i_in_item <= beat;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    // drop push, wait for every predicted byte, then let a held pixel settle
    task automatic wait_drained();
        @(negedge i_clk);
        push <= 1'b0;
        while (bytes_pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // full register set plus one write to an unmapped index, which must be dropped;
    // upper bits of the format write are junk that the block has to mask
    task automatic load_settings(input t_pix_fmt fmt, input logic [7:0] col,
                                 input logic [7:0] page, input logic [7:0] mem);
        write_reg(REG_PIXEL_FORMAT, {6'($urandom_range(0, 63)), fmt});
        write_reg(REG_COLUMN_SET_CODE, col);
        write_reg(REG_PAGE_SET_CODE, page);
        write_reg(REG_MEMORY_WRITE_CODE, mem);
        write_reg(CFG_INDEX_W'($urandom_range(4, 255)), 8'($urandom));
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // byte side: pop held high, broken by random stall bursts
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                pop <= 1'b0;
                hold_left--;
            end else if (idle_en && $urandom_range(0, 4) == 0) begin
                pop <= 1'b0;
                hold_left = $urandom_range(1, 7) - 1;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // watchdog: any accepted beat on any channel restarts the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (!empty && pop) || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int phase;
        int k;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: 24-bit pixels, default command codes
        send_beat(make_window(16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_beat(make_window(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_beat(make_window(16'h1234, 16'h00FF, 16'hFF00, 16'hA5A5));
        send_beat(make_pixel(24'h000000, 1'b0));
        send_beat(make_pixel(24'hFFFFFF, 1'b0));
        send_beat(make_pixel(24'h123456, 1'b1));

        // 16-bit packing, all-zero command codes
        wait_drained();
        load_settings(FMT_16, 8'h00, 8'h00, 8'h00);
        send_beat(make_window(16'h00F0, 16'h013F, 16'h0000, 16'h01DF));
        send_beat(make_pixel(24'hFFFFFF, 1'b1));
        send_beat(make_pixel(24'h84E718, 1'b0));

        // 18-bit packing, all-ones command codes
        wait_drained();
        load_settings(FMT_18, 8'hFF, 8'hFF, 8'hFF);
        send_beat(make_pixel(24'hFFFFFF, 1'b0));
        send_beat(make_pixel(24'h030303, 1'b1));

        // 12-bit pairing
        wait_drained();
        load_settings(FMT_12, RST_COLUMN_SET_CODE, RST_PAGE_SET_CODE, RST_MEMORY_WRITE_CODE);
        send_beat(make_pixel(24'hA1B2C3, 1'b0));   // first of a pair, held
        send_beat(make_pixel(24'hD4E5F6, 1'b0));   // partner, pair goes out
        send_beat(make_pixel(24'hFEDCBA, 1'b1));   // lone final pixel, paired with black
        send_beat(make_pixel(24'h0F0F0F, 1'b0));   // held
        send_beat(make_pixel(24'hF0F0F0, 1'b1));   // final mark on the partner of a held pixel
        send_beat(make_pixel(24'h5A5A5A, 1'b0));   // held
        send_beat(make_window(16'h0001, 16'h0002, 16'h0003, 16'h0004)); // window drops it
        send_beat(make_pixel(24'h3C3C3C, 1'b0));   // held again

        // format switch while a pixel is held: the held pixel is lost
        wait_drained();
        load_settings(FMT_24, RST_COLUMN_SET_CODE, RST_PAGE_SET_CODE, RST_MEMORY_WRITE_CODE);
        send_beat(make_pixel(24'h112233, 1'b0));
        wait_drained();
        load_settings(FMT_12, RST_COLUMN_SET_CODE, RST_PAGE_SET_CODE, RST_MEMORY_WRITE_CODE);
        send_beat(make_pixel(24'h445566, 1'b1));   // nothing held any more
        send_beat(make_pixel(24'hFFFFFF, 1'b0));
        send_beat(make_pixel(24'hFFFFFF, 1'b1));

        // random phases, each with its own register set; fills of pixel runs
        // between occasional windows, closing phase without idling
        for (phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            idle_en = (phase % 3 != 2) && (phase != PHASES - 1);
            case (phase)
                0: load_settings(FMT_12, 8'h00, 8'h00, 8'h00);
                1: load_settings(FMT_16, 8'hFF, 8'hFF, 8'hFF);
                2: load_settings(FMT_18, 8'($urandom), 8'($urandom), 8'($urandom));
                3: load_settings(FMT_24, 8'($urandom), 8'($urandom), 8'($urandom));
                4: load_settings(FMT_12, 8'($urandom), 8'($urandom), 8'($urandom));
                default: load_settings(t_pix_fmt'($urandom_range(0, 3)),
                                       8'($urandom), 8'($urandom), 8'($urandom));
            endcase
            for (k = 0; k < PHASE_BEATS; k++)
                send_beat(random_beat());
        end

        wait_drained();
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/lcdfmt_pkg.sv
hdl/lcdfmt_front.sv
hdl/lcdfmt_queue.sv
hdl/lcdfmt_back.sv
hdl/lcd_window_pixel_byte_formatter_unit.sv
tb/lcd_byte_stream_checker.sv
tb/tb.sv
